// ===== hw/rtl/region_map_insert_lookup_unit_defines.svh =====
// assertion macros for the region map unit
`ifndef REGION_MAP_INSERT_LOOKUP_UNIT_DEFINES_SVH
`define REGION_MAP_INSERT_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMAP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rmap_pkg.sv =====
// shared types, codes and constants of the region map unit
package rmap_pkg;

  localparam int unsigned ADDR_BITS       = 39;
  localparam int unsigned SIZE_BITS       = 40;
  localparam int unsigned END_BITS        = 41;
  localparam int unsigned KIND_BITS       = 16;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 40;
  localparam int unsigned MAX_ENTRIES_DEF = 256;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [END_BITS-1:0]  end_t;
  typedef logic [KIND_BITS-1:0] kind_t;

  localparam end_t  SPACE_LIMIT   = end_t'(1) << ADDR_BITS;
  localparam size_t SPACE_RESET   = size_t'(1) << ADDR_BITS;
  localparam kind_t KIND_RESERVED = 16'h0000;
  localparam kind_t KIND_UNMAPPED = 16'h0800;

  typedef struct packed {
    addr_t base;
    size_t size;
    kind_t kind;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic push;
  } chain_op_t;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPACE_SIZE  = 2'd0,
    CFG_WINDOW_BASE = 2'd1,
    CFG_WINDOW_SIZE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_INIT_FLUSH,
    S_CHECK,
    S_P1_LOAD,
    S_P1_PIECE,
    S_P1_END,
    S_P1_DEC,
    S_P2_LOAD,
    S_P2_PIECE,
    S_P2_END,
    S_P2_FLUSH,
    S_LOOK,
    S_DONE
  } fsm_t;

endpackage

// ===== hw/rtl/rmap_cell.sv =====
// one table cell: holds a region, shifts toward the head or loads a pushed region
module rmap_cell #(
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                clk,
  input  rmap_pkg::chain_op_t op,
  input  logic [IDX_W-1:0]    push_idx,
  input  rmap_pkg::entry_t    push_word,
  input  rmap_pkg::entry_t    next_word,
  output rmap_pkg::entry_t    word
);

  rmap_pkg::entry_t word_r;
  logic             match;

  assign match = op.push && (push_idx == IDX_W'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (op.shift) begin
      word_r <= match ? push_word : next_word;
    end else if (match) begin
      word_r <= push_word;
    end
  end

  assign word = word_r;

endmodule

// ===== hw/rtl/rmap_chain.sv =====
// row of region cells, head at cell zero
module rmap_chain #(
  parameter int unsigned MAX_ENTRIES = rmap_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned IDX_W       = $clog2(MAX_ENTRIES)
) (
  input  logic                clk,
  input  rmap_pkg::chain_op_t op,
  input  logic [IDX_W-1:0]    push_idx,
  input  rmap_pkg::entry_t    push_word,
  output rmap_pkg::entry_t    head
);

  rmap_pkg::entry_t words [MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    rmap_pkg::entry_t nxt_word;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nxt_word = push_word;
    end else begin : g_mid
      assign nxt_word = words[i+1];
    end
    rmap_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .push_idx  (push_idx),
      .push_word (push_word),
      .next_word (nxt_word),
      .word      (words[i])
    );
  end

  assign head = words[0];

endmodule

// ===== hw/rtl/region_map_insert_lookup_unit.sv =====
// top level: sorted region table with init, range insert and address lookup
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------------
//  input    | start / busy      | in_opcode, in_region_base/size/state/perm/attr
//  result   | out_valid strobe  | out_status, out_found, out_hit_base/size/state/..
//  config   | cfg_we            | cfg_index, cfg_wdata
//
//  lookup scans the cell row, one cell per cycle
//  insert walks the cell row in a count pass, then a rebuild pass unless the table is full:
//  each pass handles at most count + 2 pieces, one per cycle
//  a word is taken only while busy is low; one result word per input word
//  results show for one cycle on out_valid; the receiver cannot stall
//  reset empties the table; no clearing pass is needed
module region_map_insert_lookup_unit #(
  parameter int unsigned MAX_ENTRIES = rmap_pkg::MAX_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_opcode,
  input  logic [38:0]                        in_region_base,
  input  logic [39:0]                        in_region_size,
  input  logic [4:0]                         in_region_state,
  input  logic [2:0]                         in_region_perm,
  input  logic [7:0]                         in_region_attr,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic                               out_found,
  output logic [38:0]                        out_hit_base,
  output logic [39:0]                        out_hit_size,
  output logic [4:0]                         out_hit_state,
  output logic [2:0]                         out_hit_perm,
  output logic [7:0]                         out_hit_attr,
  input  logic                               cfg_we,
  input  logic [rmap_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rmap_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  `include "region_map_insert_lookup_unit_defines.svh"

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  rmap_pkg::fsm_t    state_r, state_nxt;
  rmap_pkg::size_t   space_size_r;
  rmap_pkg::addr_t   window_base_r;
  rmap_pkg::size_t   window_size_r;
  logic [CNT_W-1:0]  occ_r, rem_r, ncnt_r;
  rmap_pkg::end_t    tab_end_r;
  rmap_pkg::addr_t   cb_r;
  rmap_pkg::size_t   cs_r;
  rmap_pkg::end_t    ce_r;
  rmap_pkg::kind_t   ck_r;
  rmap_pkg::addr_t   cur_b_r;
  rmap_pkg::end_t    cur_e_r;
  rmap_pkg::kind_t   cur_k_r;
  logic [2:0]        mask_r;
  logic              new_done_r;
  logic [1:0]        step_r;
  rmap_pkg::entry_t  pend_r;
  logic              pend_v_r;
  logic              full_r;
  logic              found_r;
  rmap_pkg::status_t status_r;
  rmap_pkg::entry_t  hit_r;

  rmap_pkg::entry_t    head;
  rmap_pkg::end_t      head_end;
  rmap_pkg::chain_op_t cop;
  logic [IDX_W-1:0]    push_idx;
  rmap_pkg::entry_t    push_word;

  logic           accept, rot, consume, load, write_mode, flush, count_mode;
  logic           ld_b, ld_n, ld_a, look_hit, range_bad;
  logic [2:0]     low_bit, mask_left, ld_mask;
  logic           pv;
  rmap_pkg::entry_t pc;
  rmap_pkg::end_t pend_end, cb_e, lo_e, min_e;
  rmap_pkg::end_t sp, ws, we_raw, we;
  logic           em_take, merge, em_push, em_full;

  assign accept = start && !busy;

  rmap_chain #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_chain (
    .clk       (clk),
    .op        (cop),
    .push_idx  (push_idx),
    .push_word (push_word),
    .head      (head)
  );

  // entry and insert geometry
  assign head_end = {2'b00, head.base} + {1'b0, head.size};
  assign cb_e     = {2'b00, cb_r};
  assign ld_b     = head.base < cb_r;
  assign ld_a     = head_end > ce_r;
  assign ld_n     = !new_done_r && ld_a;
  assign ld_mask  = {ld_a, ld_n, ld_b};
  assign look_hit = (head.base <= cb_r) && (cb_e < head_end);
  assign range_bad = (occ_r == '0) || (cb_r < head.base) || (ce_r > tab_end_r);

  assign low_bit   = mask_r & (~mask_r + 3'd1);
  assign mask_left = mask_r & ~low_bit;

  // init geometry from the registers
  assign sp     = ({1'b0, space_size_r} > rmap_pkg::SPACE_LIMIT) ? rmap_pkg::SPACE_LIMIT
                                                                 : {1'b0, space_size_r};
  assign ws     = ({2'b00, window_base_r} < sp) ? {2'b00, window_base_r} : sp;
  assign we_raw = {2'b00, window_base_r} + {1'b0, window_size_r};
  assign we     = (we_raw > sp) ? sp : we_raw;

  assign min_e = (cur_e_r < cb_e) ? cur_e_r : cb_e;
  assign lo_e  = ({2'b00, cur_b_r} > ce_r) ? {2'b00, cur_b_r} : ce_r;

  // piece that goes to the merge stage this cycle
  always_comb begin
    pv = 1'b0;
    pc = '0;
    case (state_r)
      rmap_pkg::S_INIT: begin
        pv = 1'b1;
        case (step_r)
          2'd0: pc = '{base: '0, size: ws[39:0], kind: rmap_pkg::KIND_RESERVED};
          2'd1: pc = '{base: ws[38:0], size: 40'(we - ws), kind: rmap_pkg::KIND_UNMAPPED};
          default: pc = '{base: we[38:0], size: 40'(sp - we), kind: rmap_pkg::KIND_RESERVED};
        endcase
      end
      rmap_pkg::S_P1_PIECE, rmap_pkg::S_P2_PIECE: begin
        pv = 1'b1;
        if (low_bit[0]) begin
          pc = '{base: cur_b_r, size: 40'(min_e - {2'b00, cur_b_r}), kind: cur_k_r};
        end else if (low_bit[1]) begin
          pc = '{base: cb_r, size: cs_r, kind: ck_r};
        end else begin
          pc = '{base: lo_e[38:0], size: 40'(cur_e_r - lo_e), kind: cur_k_r};
        end
      end
      rmap_pkg::S_P1_END, rmap_pkg::S_P2_END: begin
        pv = !new_done_r;
        pc = '{base: cb_r, size: cs_r, kind: ck_r};
      end
      default: begin
        pv = 1'b0;
      end
    endcase
  end

  // merge with the pending region or retire it
  assign pend_end = {2'b00, pend_r.base} + {1'b0, pend_r.size};
  assign em_take  = pv && (pc.size != '0);
  assign merge    = pend_v_r && (pend_r.kind == pc.kind) && (pend_end == {2'b00, pc.base});
  assign em_full  = em_take && !merge && count_mode && (ncnt_r == CNT_W'(MAX_ENTRIES));
  assign em_push  = em_take && !merge && pend_v_r && write_mode;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmap_pkg::S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            rmap_pkg::OP_INIT:   state_nxt = rmap_pkg::S_INIT;
            rmap_pkg::OP_INSERT: state_nxt = rmap_pkg::S_CHECK;
            rmap_pkg::OP_LOOKUP: state_nxt = rmap_pkg::S_LOOK;
            default:             state_nxt = rmap_pkg::S_DONE;
          endcase
        end
      end
      rmap_pkg::S_INIT: begin
        if (step_r == 2'd2) state_nxt = rmap_pkg::S_INIT_FLUSH;
      end
      rmap_pkg::S_INIT_FLUSH: state_nxt = rmap_pkg::S_DONE;
      rmap_pkg::S_CHECK: begin
        if (cs_r == '0 || range_bad) begin
          state_nxt = rmap_pkg::S_DONE;
        end else begin
          state_nxt = rmap_pkg::S_P1_LOAD;
        end
      end
      rmap_pkg::S_P1_LOAD: begin
        if (rem_r == '0) begin
          state_nxt = rmap_pkg::S_P1_END;
        end else if (ld_mask != 3'b000) begin
          state_nxt = rmap_pkg::S_P1_PIECE;
        end
      end
      rmap_pkg::S_P1_PIECE: begin
        if (mask_left == 3'b000) state_nxt = rmap_pkg::S_P1_LOAD;
      end
      rmap_pkg::S_P1_END: state_nxt = rmap_pkg::S_P1_DEC;
      rmap_pkg::S_P1_DEC: begin
        state_nxt = full_r ? rmap_pkg::S_DONE : rmap_pkg::S_P2_LOAD;
      end
      rmap_pkg::S_P2_LOAD: begin
        if (rem_r == '0) begin
          state_nxt = rmap_pkg::S_P2_END;
        end else if (ld_mask != 3'b000) begin
          state_nxt = rmap_pkg::S_P2_PIECE;
        end
      end
      rmap_pkg::S_P2_PIECE: begin
        if (mask_left == 3'b000) state_nxt = rmap_pkg::S_P2_LOAD;
      end
      rmap_pkg::S_P2_END:   state_nxt = rmap_pkg::S_P2_FLUSH;
      rmap_pkg::S_P2_FLUSH: state_nxt = rmap_pkg::S_DONE;
      rmap_pkg::S_LOOK: begin
        if (rem_r == '0) state_nxt = rmap_pkg::S_DONE;
      end
      rmap_pkg::S_DONE: state_nxt = rmap_pkg::S_IDLE;
      default: state_nxt = rmap_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    rot        = 1'b0;
    consume    = 1'b0;
    load       = 1'b0;
    write_mode = 1'b0;
    count_mode = 1'b0;
    flush      = 1'b0;
    case (state_r)
      rmap_pkg::S_P1_LOAD: begin
        rot        = rem_r != '0;
        load       = rem_r != '0;
        count_mode = 1'b1;
      end
      rmap_pkg::S_P1_PIECE, rmap_pkg::S_P1_END: count_mode = 1'b1;
      rmap_pkg::S_P2_LOAD: begin
        consume    = rem_r != '0;
        load       = rem_r != '0;
        write_mode = 1'b1;
      end
      rmap_pkg::S_P2_PIECE, rmap_pkg::S_P2_END, rmap_pkg::S_INIT: write_mode = 1'b1;
      rmap_pkg::S_P2_FLUSH, rmap_pkg::S_INIT_FLUSH: begin
        write_mode = 1'b1;
        flush      = 1'b1;
      end
      rmap_pkg::S_LOOK: rot = rem_r != '0;
      default: begin
        rot = 1'b0;
      end
    endcase
  end

  assign cop.shift = rot || consume;
  assign cop.push  = rot || em_push || (flush && pend_v_r);
  assign push_word = rot ? head : pend_r;
  assign push_idx  = rot ? IDX_W'(occ_r - CNT_W'(1)) : occ_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rmap_pkg::S_IDLE;
      space_size_r  <= rmap_pkg::SPACE_RESET;
      window_base_r <= '0;
      window_size_r <= '0;
      occ_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rmap_pkg::CFG_SPACE_SIZE:  space_size_r  <= cfg_wdata;
          rmap_pkg::CFG_WINDOW_BASE: window_base_r <= cfg_wdata[38:0];
          rmap_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && in_opcode == rmap_pkg::OP_INIT) begin
        occ_r <= '0;
      end else if (consume) begin
        occ_r <= occ_r - CNT_W'(1);
      end else if (cop.push && !rot) begin
        occ_r <= occ_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cb_r       <= in_region_base;
      cs_r       <= in_region_size;
      ce_r       <= {2'b00, in_region_base} + {1'b0, in_region_size};
      ck_r       <= {in_region_state, in_region_perm, in_region_attr};
      rem_r      <= occ_r;
      step_r     <= '0;
      pend_v_r   <= 1'b0;
      ncnt_r     <= '0;
      new_done_r <= 1'b0;
      full_r     <= 1'b0;
      found_r    <= 1'b0;
      status_r   <= rmap_pkg::ST_OK;
      hit_r      <= '0;
      if (in_opcode == rmap_pkg::OP_INIT) tab_end_r <= sp;
    end else begin
      if (state_r == rmap_pkg::S_INIT) step_r <= step_r + 2'd1;
      if (state_r == rmap_pkg::S_CHECK && cs_r != '0 && range_bad) begin
        status_r <= rmap_pkg::ST_RANGE;
      end
      if (state_r == rmap_pkg::S_P1_DEC) begin
        rem_r      <= occ_r;
        pend_v_r   <= 1'b0;
        new_done_r <= 1'b0;
        if (full_r) status_r <= rmap_pkg::ST_FULL;
      end
      if (rot || consume) rem_r <= rem_r - CNT_W'(1);
      if (load) begin
        cur_b_r <= head.base;
        cur_e_r <= head_end;
        cur_k_r <= head.kind;
        mask_r  <= ld_mask;
        if (ld_n) new_done_r <= 1'b1;
      end else if (state_r == rmap_pkg::S_P1_PIECE || state_r == rmap_pkg::S_P2_PIECE) begin
        mask_r <= mask_left;
      end
      if (em_take) begin
        if (merge) begin
          pend_r.size <= pend_r.size + pc.size;
        end else if (em_full) begin
          full_r <= 1'b1;
        end else begin
          pend_r   <= pc;
          pend_v_r <= 1'b1;
          ncnt_r   <= ncnt_r + CNT_W'(1);
        end
      end
      if (flush) pend_v_r <= 1'b0;
      if (state_r == rmap_pkg::S_LOOK && rot && look_hit && !found_r) begin
        found_r <= 1'b1;
        hit_r   <= head;
      end
    end
  end

  assign busy          = state_r != rmap_pkg::S_IDLE;
  assign out_valid     = state_r == rmap_pkg::S_DONE;
  assign out_status    = status_r;
  assign out_found     = found_r;
  assign out_hit_base  = hit_r.base;
  assign out_hit_size  = hit_r.size;
  assign out_hit_state = hit_r.kind[15:11];
  assign out_hit_perm  = hit_r.kind[10:8];
  assign out_hit_attr  = hit_r.kind[7:0];

  `RMAP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `RMAP_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r <= CNT_W'(MAX_ENTRIES), "table count overflow")
  `RMAP_ASSERT_IMPL(a_push_room, cop.push && !rot, occ_r < CNT_W'(MAX_ENTRIES), "push into full row")

endmodule
